// ----- rtl/core/sttb_pkg.sv -----
// ----------------------------------------------------------------------------
// sttb_pkg
// Shared types, action codes and default sizes of the timeout timer bank.
// ----------------------------------------------------------------------------
package sttb_pkg;

  localparam int ONESHOT_CHANNELS_DEF = 4;
  localparam int REPEAT_CHANNELS_DEF  = 3;
  localparam int ONESHOT_BITS_DEF     = 16;
  localparam int REPEAT_BITS_DEF      = 8;

  localparam int ACTION_W  = 2;
  localparam int CHANNEL_W = 2;
  localparam int DELAY_W   = 16;
  localparam int OS_FLAGS_W = 4;
  localparam int RP_FLAGS_W = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_START_OS = 2'd1,
    ACT_START_RP = 2'd2
  } action_t;

  // decoded command handed to both channel banks
  typedef struct packed {
    logic                 tick;
    logic                 start_os;
    logic                 start_rp;
    logic [CHANNEL_W-1:0] channel;
    logic [DELAY_W-1:0]   delay;
  } cmd_t;

endpackage

// ----- rtl/core/sttb_ifs.sv -----
// ----------------------------------------------------------------------------
// sttb channel interfaces
// Valid/ready channels for command beats and flag result beats.
// ----------------------------------------------------------------------------
interface sttb_in_if import sttb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [CHANNEL_W-1:0] channel;
  logic [DELAY_W-1:0]   delay;

  modport source (output valid, output action, output channel, output delay, input ready);
  modport sink   (input valid, input action, input channel, input delay, output ready);
endinterface

interface sttb_out_if import sttb_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [OS_FLAGS_W-1:0] oneshot_flags;
  logic [RP_FLAGS_W-1:0] repeat_flags;
  logic                  half_tick;

  modport source (output valid, output oneshot_flags, output repeat_flags,
                  output half_tick, input ready);
  modport sink   (input valid, input oneshot_flags, input repeat_flags,
                  input half_tick, output ready);
endinterface

// ----- rtl/core/sttb_oneshot_bank.sv -----
// ----------------------------------------------------------------------------
// sttb_oneshot_bank
// One-shot counters with sticky expiry flags; all channels tick in parallel.
// ----------------------------------------------------------------------------
module sttb_oneshot_bank import sttb_pkg::*; #(
  parameter int CHANNELS = ONESHOT_CHANNELS_DEF,
  parameter int BITS     = ONESHOT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cmd_t                cmd,
  output logic [CHANNELS-1:0] flag_nxt
);

  logic [BITS-1:0]     count_r   [CHANNELS];
  logic [BITS-1:0]     count_nxt [CHANNELS];
  logic [CHANNELS-1:0] flag_r;
  logic [31:0]         delay_ext;
  logic [BITS-1:0]     load_val;

  assign delay_ext = {{(32-DELAY_W){1'b0}}, cmd.delay};
  assign load_val  = delay_ext[BITS-1:0];

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      count_nxt[i] = count_r[i];
      flag_nxt[i]  = flag_r[i];
      if (cmd.tick) begin
        count_nxt[i] = count_r[i] - 1'b1;
        // new count is zero
        if (count_r[i] == BITS'(1)) flag_nxt[i] = 1'b1;
      end else if (cmd.start_os && (32'(cmd.channel) == i)) begin
        count_nxt[i] = load_val;
        flag_nxt[i]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= '0;
      for (int i = 0; i < CHANNELS; i++) count_r[i] <= '0;
    end else if (en) begin
      flag_r <= flag_nxt;
      for (int i = 0; i < CHANNELS; i++) count_r[i] <= count_nxt[i];
    end
  end

endmodule

// ----- rtl/core/sttb_repeat_bank.sv -----
// ----------------------------------------------------------------------------
// sttb_repeat_bank
// Auto-reload counters with reload values and sticky expiry flags.
// ----------------------------------------------------------------------------
module sttb_repeat_bank import sttb_pkg::*; #(
  parameter int CHANNELS = REPEAT_CHANNELS_DEF,
  parameter int BITS     = REPEAT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cmd_t                cmd,
  output logic [CHANNELS-1:0] flag_nxt
);

  logic [BITS-1:0]     count_r    [CHANNELS];
  logic [BITS-1:0]     count_nxt  [CHANNELS];
  logic [BITS-1:0]     reload_r   [CHANNELS];
  logic [BITS-1:0]     reload_nxt [CHANNELS];
  logic [CHANNELS-1:0] flag_r;
  logic [31:0]         delay_ext;
  logic [BITS-1:0]     load_val;

  assign delay_ext = {{(32-DELAY_W){1'b0}}, cmd.delay};
  assign load_val  = delay_ext[BITS-1:0];

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      count_nxt[i]  = count_r[i];
      reload_nxt[i] = reload_r[i];
      flag_nxt[i]   = flag_r[i];
      if (cmd.tick) begin
        // reaching zero reloads in the same tick
        if (count_r[i] == BITS'(1)) begin
          count_nxt[i] = reload_r[i];
          flag_nxt[i]  = 1'b1;
        end else begin
          count_nxt[i] = count_r[i] - 1'b1;
        end
      end else if (cmd.start_rp && (32'(cmd.channel) == i)) begin
        count_nxt[i]  = load_val;
        reload_nxt[i] = load_val;
        flag_nxt[i]   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        count_r[i]  <= '0;
        reload_r[i] <= '0;
      end
    end else if (en) begin
      flag_r <= flag_nxt;
      for (int i = 0; i < CHANNELS; i++) begin
        count_r[i]  <= count_nxt[i];
        reload_r[i] <= reload_nxt[i];
      end
    end
  end

endmodule

// ----- rtl/core/software_timeout_timer_bank_core.sv -----
// ----------------------------------------------------------------------------
// software_timeout_timer_bank_core
// Tick-driven bank of one-shot and auto-reload timeouts with sticky flags.
// ----------------------------------------------------------------------------
// Takes one command beat per clock while results are being taken, and returns one result beat per command.
// A beat is registered on entry, the channel banks update all counters in
// parallel as it moves on, and the flags after that update are registered in
// the result stage.
// Throughput is one beat per cycle while out_bus.ready is high; a waiting
// result stalls the entry register only once it too is full.
module software_timeout_timer_bank_core import sttb_pkg::*; #(
  parameter int ONESHOT_CHANNELS = ONESHOT_CHANNELS_DEF,
  parameter int REPEAT_CHANNELS  = REPEAT_CHANNELS_DEF,
  parameter int ONESHOT_BITS     = ONESHOT_BITS_DEF,
  parameter int REPEAT_BITS      = REPEAT_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sttb_in_if.sink   in_bus,
  sttb_out_if.source out_bus
);

  logic                 in_valid_r;
  logic [ACTION_W-1:0]  action_r;
  logic [CHANNEL_W-1:0] channel_r;
  logic [DELAY_W-1:0]   delay_r;

  logic                  out_valid_r;
  logic [OS_FLAGS_W-1:0] os_flags_r;
  logic [RP_FLAGS_W-1:0] rp_flags_r;
  logic                  half_r;
  logic                  phase_r;

  logic advance;
  logic step;
  cmd_t cmd;
  logic [ONESHOT_CHANNELS-1:0] os_flag_nxt;
  logic [REPEAT_CHANNELS-1:0]  rp_flag_nxt;
  logic [OS_FLAGS_W-1:0]       os_flags_nxt;
  logic [RP_FLAGS_W-1:0]       rp_flags_nxt;

  assign advance      = !out_valid_r || out_bus.ready;
  assign step         = in_valid_r && advance;
  assign in_bus.ready = !in_valid_r || advance;

  always_comb begin
    cmd          = '0;
    cmd.channel  = channel_r;
    cmd.delay    = delay_r;
    unique case (action_r)
      ACT_TICK:     cmd.tick     = 1'b1;
      ACT_START_OS: cmd.start_os = 1'b1;
      ACT_START_RP: cmd.start_rp = 1'b1;
      default:      ;
    endcase
  end

  sttb_oneshot_bank #(
    .CHANNELS (ONESHOT_CHANNELS),
    .BITS     (ONESHOT_BITS)
  ) u_oneshot (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (step),
    .cmd      (cmd),
    .flag_nxt (os_flag_nxt)
  );

  sttb_repeat_bank #(
    .CHANNELS (REPEAT_CHANNELS),
    .BITS     (REPEAT_BITS)
  ) u_repeat (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (step),
    .cmd      (cmd),
    .flag_nxt (rp_flag_nxt)
  );

  // channels beyond the field width are not reported
  always_comb begin
    os_flags_nxt = '0;
    rp_flags_nxt = '0;
    for (int i = 0; i < OS_FLAGS_W; i++)
      if (i < ONESHOT_CHANNELS) os_flags_nxt[i] = os_flag_nxt[i];
    for (int i = 0; i < RP_FLAGS_W; i++)
      if (i < REPEAT_CHANNELS) rp_flags_nxt[i] = rp_flag_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (in_bus.ready) in_valid_r <= in_bus.valid;
      if (advance) out_valid_r <= in_valid_r;
      if (step && cmd.tick) phase_r <= !phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready) begin
      action_r  <= in_bus.action;
      channel_r <= in_bus.channel;
      delay_r   <= in_bus.delay;
    end
    if (step) begin
      os_flags_r <= os_flags_nxt;
      rp_flags_r <= rp_flags_nxt;
      half_r     <= cmd.tick && !phase_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.oneshot_flags = os_flags_r;
  assign out_bus.repeat_flags  = rp_flags_r;
  assign out_bus.half_tick     = half_r;

endmodule

// ----- sim/tb_software_timeout_timer_bank_core.sv -----
// ----------------------------------------------------------------------------
// tb_software_timeout_timer_bank_core
// Self-checking bench for the timeout timer bank. Sends tick and start beats
// with random idling and receiver stalls, tracks the counters and sticky
// flags in a local timer model, and checks each result beat in order.
// ----------------------------------------------------------------------------
module tb_software_timeout_timer_bank_core;
  import sttb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OS_CH   = ONESHOT_CHANNELS_DEF;
  localparam int RP_CH   = REPEAT_CHANNELS_DEF;
  localparam int OS_BITS = ONESHOT_BITS_DEF;
  localparam int RP_BITS = REPEAT_BITS_DEF;

  // action code the block leaves unused
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int PLAN_LEN     = 22;
  localparam int RAND_BEATS   = 120;
  localparam int HOLD_BEATS   = 30;
  localparam int HOLD_CYCLES  = 40;
  localparam int BURST_TICKS  = 260;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [OS_FLAGS_W-1:0] oneshot;
    logic [RP_FLAGS_W-1:0] repeats;
    logic                  half;
  } flags_t;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [CHANNEL_W-1:0] channel;
    logic [DELAY_W-1:0]   delay;
    logic                 typed;
    flags_t               flags;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  sttb_in_if  in_bus ();
  sttb_out_if out_bus ();

  software_timeout_timer_bank_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // timer model state
  logic [OS_BITS-1:0] os_count  [OS_CH];
  logic               os_flag   [OS_CH];
  logic [RP_BITS-1:0] rp_count  [RP_CH];
  logic [RP_BITS-1:0] rp_reload [RP_CH];
  logic               rp_flag   [RP_CH];
  logic               tick_phase;

  flags_t    pending_flags[$];
  plan_row_t plan [PLAN_LEN];
  int        errors     = 0;
  int        idle_pct   = 0;
  int        stall_pct  = 0;
  bit        valid_up   = 1'b0;
  logic      hold_on    = 1'b0;
  event      hold_go;

  // applies one command beat to the model and returns the flags after it
  function automatic flags_t advance_timers(logic [ACTION_W-1:0] act,
                                            logic [CHANNEL_W-1:0] ch,
                                            logic [DELAY_W-1:0] dly);
    flags_t res;
    res = '0;
    case (act)
      ACT_TICK: begin
        for (int i = 0; i < OS_CH; i++) begin
          os_count[i] = os_count[i] - 1'b1;
          if (os_count[i] == '0) os_flag[i] = 1'b1;
        end
        for (int i = 0; i < RP_CH; i++) begin
          rp_count[i] = rp_count[i] - 1'b1;
          if (rp_count[i] == '0) begin
            rp_flag[i]  = 1'b1;
            rp_count[i] = rp_reload[i];
          end
        end
        tick_phase = ~tick_phase;
        res.half   = tick_phase;
      end
      ACT_START_OS: begin
        if (ch < OS_CH) begin
          os_flag[ch]  = 1'b0;
          os_count[ch] = dly[OS_BITS-1:0];
        end
      end
      ACT_START_RP: begin
        if (ch < RP_CH) begin
          rp_flag[ch]   = 1'b0;
          rp_count[ch]  = dly[RP_BITS-1:0];
          rp_reload[ch] = dly[RP_BITS-1:0];
        end
      end
      default: ;
    endcase
    for (int i = 0; i < OS_CH && i < OS_FLAGS_W; i++) res.oneshot[i] = os_flag[i];
    for (int i = 0; i < RP_CH && i < RP_FLAGS_W; i++) res.repeats[i] = rp_flag[i];
    return res;
  endfunction

  task automatic lower_valid();
    if (valid_up) begin
      in_bus.valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // offers one beat, waits for it to be taken, then idles at random
  task automatic send_beat(logic [ACTION_W-1:0] act, logic [CHANNEL_W-1:0] ch,
                           logic [DELAY_W-1:0] dly, logic typed, flags_t typed_res);
    flags_t predicted;
    in_bus.valid   <= 1'b1;
    in_bus.action  <= act;
    in_bus.channel <= ch;
    in_bus.delay   <= dly;
    valid_up = 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predicted = advance_timers(act, ch, dly);
    pending_flags.push_back(typed ? typed_res : predicted);
    while ($urandom_range(99) < idle_pct) begin
      lower_valid();
      @(posedge clk);
    end
  endtask

  function automatic logic [DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 25) return DELAY_W'($urandom);
    if (r < 40) return {8'($urandom), 8'($urandom_range(1, 8))};
    return DELAY_W'($urandom_range(1, 8));
  endfunction

  // mostly ticks and short starts so that flags keep expiring
  task automatic send_random_beat();
    int r;
    logic [ACTION_W-1:0] act;
    r = $urandom_range(99);
    if (r < 50) act = ACT_TICK;
    else if (r < 73) act = ACT_START_OS;
    else if (r < 96) act = ACT_START_RP;
    else act = ACT_UNUSED;
    send_beat(act, CHANNEL_W'($urandom_range(3)), pick_delay(), 1'b0, '0);
  endtask

  task automatic wait_all_results();
    lower_valid();
    while (pending_flags.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial forever begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    out_bus.ready <= !hold_on && ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    flags_t got;
    flags_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.oneshot_flags, out_bus.repeat_flags, out_bus.half_tick};
      if (pending_flags.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t unexpected result beat os=%h rp=%h half=%b",
                   $realtime, got.oneshot, got.repeats, got.half);
      end else begin
        want = pending_flags.pop_front();
        if (got.oneshot !== want.oneshot || got.repeats !== want.repeats ||
            got.half !== want.half) begin
          errors++;
          if (errors <= 10)
            $display("%0t mismatch: exp os=%h rp=%h half=%b, got os=%h rp=%h half=%b",
                     $realtime, want.oneshot, want.repeats, want.half,
                     got.oneshot, got.repeats, got.half);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    plan = '{
      // straight after reset every counter wraps, nothing expires
      '{ACT_TICK,     2'd0, 16'h0000, 1'b1, '{4'h0, 3'h0, 1'b1}},
      '{ACT_TICK,     2'd0, 16'h0000, 1'b1, '{4'h0, 3'h0, 1'b0}},
      '{ACT_UNUSED,   2'd3, 16'hFFFF, 1'b1, '{4'h0, 3'h0, 1'b0}},
      '{ACT_START_OS, 2'd0, 16'h0001, 1'b1, '{4'h0, 3'h0, 1'b0}},
      '{ACT_TICK,     2'd0, 16'h0000, 1'b1, '{4'h1, 3'h0, 1'b1}},
      // auto-reload channel index past the bank
      '{ACT_START_RP, 2'd3, 16'h0005, 1'b1, '{4'h1, 3'h0, 1'b0}},
      '{ACT_START_RP, 2'd0, 16'h0001, 1'b1, '{4'h1, 3'h0, 1'b0}},
      '{ACT_TICK,     2'd0, 16'h0000, 1'b1, '{4'h1, 3'h1, 1'b0}},
      '{ACT_TICK,     2'd1, 16'hFFFF, 1'b0, '0},
      '{ACT_START_OS, 2'd3, 16'hFFFF, 1'b0, '0},
      '{ACT_START_OS, 2'd1, 16'h0000, 1'b0, '0},
      '{ACT_START_OS, 2'd2, 16'h0002, 1'b0, '0},
      // low byte zero: zero reload
      '{ACT_START_RP, 2'd2, 16'hFF00, 1'b0, '0},
      '{ACT_START_RP, 2'd1, 16'h00FF, 1'b0, '0},
      '{ACT_START_OS, 2'd0, 16'hAAAA, 1'b0, '0},
      '{ACT_TICK,     2'd0, 16'h0000, 1'b0, '0},
      '{ACT_TICK,     2'd2, 16'h5555, 1'b0, '0},
      '{ACT_TICK,     2'd0, 16'h0000, 1'b0, '0},
      '{ACT_TICK,     2'd3, 16'h0000, 1'b0, '0},
      '{ACT_UNUSED,   2'd0, 16'h5555, 1'b0, '0},
      '{ACT_START_OS, 2'd3, 16'h0000, 1'b0, '0},
      '{ACT_TICK,     2'd0, 16'h0000, 1'b0, '0}
    };
  end

  initial begin
    int idle_set  [4];
    int stall_set [4];
    idle_set  = '{0, 61, 0, 34};
    stall_set = '{0, 0, 61, 34};

    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.action  <= ACT_TICK;
    in_bus.channel <= '0;
    in_bus.delay   <= '0;
    for (int i = 0; i < OS_CH; i++) begin
      os_count[i] = '0;
      os_flag[i]  = 1'b0;
    end
    for (int i = 0; i < RP_CH; i++) begin
      rp_count[i]  = '0;
      rp_reload[i] = '0;
      rp_flag[i]   = 1'b0;
    end
    tick_phase = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i])
      send_beat(plan[i].action, plan[i].channel, plan[i].delay,
                plan[i].typed, plan[i].flags);
    wait_all_results();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      if (ph == 0) begin
        // receiver holds off while beats keep coming, so the input backs up
        -> hold_go;
        repeat (HOLD_BEATS) send_random_beat();
        wait_all_results();
      end
      if (ph == 3) begin
        // long tick run: zero reload and 8-bit wrap periods come round
        send_beat(ACT_START_RP, 2'd2, 16'h3400, 1'b0, '0);
        send_beat(ACT_START_RP, 2'd1, 16'h00FF, 1'b0, '0);
        send_beat(ACT_START_OS, 2'd1, 16'h0100, 1'b0, '0);
        repeat (BURST_TICKS) send_beat(ACT_TICK, CHANNEL_W'($urandom_range(3)),
                                       DELAY_W'($urandom), 1'b0, '0);
      end
      repeat (RAND_BEATS) send_random_beat();
      wait_all_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
